@@ hw/rtl/cdll_pkg.sv @@
// Shared types, codes and defaults for the circular doubly linked list unit.
`default_nettype none

package cdll_pkg;

  // Default sizes of the store and of one listing.
  localparam int Capacity  = 16;
  localparam int ListLimit = 10;

  // Operation codes carried in the request.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LIST   = 2'd2,
    FUNC_NONE   = 2'd3
  } cdll_func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_LISTED   = 3'd4
  } cdll_status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_WALK
  } cdll_state_e;

  // One request.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } cdll_req_t;

  // One result.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic [4:0]         entries;
    logic               last;
  } cdll_res_t;

  // Commands from the controller to the row of cells.
  typedef struct packed {
    logic wr;    // write the new value into the cell just past the tail
    logic rot;   // rotate: head moves to the tail, the rest move down
    logic drop;  // drop the head: every cell takes its neighbour's value
  } cdll_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/cdll_cell.sv @@
// One cell of the list row: holds one value and takes its neighbour's on a move.
`default_nettype none

module cdll_cell #(
  parameter int Capacity = cdll_pkg::Capacity,
  parameter int Idx      = 0,
  localparam int CntW    = $clog2(Capacity + 1)
) (
  input  wire logic               clk_i,
  input  wire cdll_pkg::cdll_cmd_t cmd_i,
  input  wire logic [CntW-1:0]    count_i,
  input  wire logic signed [31:0] wdata_i,
  input  wire logic signed [31:0] nb_value_i,
  input  wire logic signed [31:0] head_value_i,
  output logic signed [31:0]      value_o
);

  logic signed [31:0] value_q, value_d;
  logic               is_tail;
  logic               is_free;

  // Position of this cell relative to the current end of the list.
  assign is_tail = (CntW'(Idx) + 1'b1) == count_i;
  assign is_free = CntW'(Idx) == count_i;

  // A rotation wraps the head into the tail cell; a drop only shifts down.
  always_comb begin
    value_d = value_q;
    if (cmd_i.wr && is_free) begin
      value_d = wdata_i;
    end else if (cmd_i.rot) begin
      value_d = is_tail ? head_value_i : nb_value_i;
    end else if (cmd_i.drop) begin
      value_d = nb_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ hw/rtl/cdll_ctrl.sv @@
// Sequencer that walks the list row and forms the results.
`default_nettype none

module cdll_ctrl #(
  parameter int Capacity  = cdll_pkg::Capacity,
  parameter int ListLimit = cdll_pkg::ListLimit,
  localparam int CntW     = $clog2(Capacity + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire cdll_pkg::cdll_req_t req_i,
  input  wire logic signed [31:0]  head_value_i,
  output cdll_pkg::cdll_cmd_t      cmd_o,
  output logic [CntW-1:0]          count_o,
  output logic signed [31:0]       wdata_o,
  output logic                     res_strobe_o,
  output cdll_pkg::cdll_res_t      res_o
);

  cdll_pkg::cdll_state_e state_q, state_d;
  cdll_pkg::cdll_func_e  op_q, op_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       step_q, step_d;
  logic [CntW-1:0]       len_q, len_d;
  logic [CntW-1:0]       shown_q, shown_d;
  logic signed [31:0]    val_q, val_d;
  logic                  found_q, found_d;
  logic                  strobe_q, strobe_d;
  cdll_pkg::cdll_res_t   res_q, res_d;
  cdll_pkg::cdll_cmd_t   cmd;
  logic                  accept;
  logic                  walk_req;
  logic                  last_step;
  logic                  match;

  assign accept    = start && (state_q == cdll_pkg::S_IDLE);
  assign walk_req  = ((req_i.func == cdll_pkg::FUNC_DELETE) ||
                      (req_i.func == cdll_pkg::FUNC_LIST)) && (count_q != '0);
  assign last_step = step_q == (len_q - 1'b1);
  assign match     = !found_q && (head_value_i == val_q);

  // Next state: a delete or list on a non-empty list starts a walk, which ends after the last entry's step.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cdll_pkg::S_IDLE: begin
        if (accept && walk_req) begin
          state_d = cdll_pkg::S_WALK;
        end
      end
      cdll_pkg::S_WALK: begin
        if (last_step) begin
          state_d = cdll_pkg::S_IDLE;
        end
      end
      default: state_d = cdll_pkg::S_IDLE;
    endcase
  end

  // Outputs: commands to the cells, bookkeeping and the next result.
  always_comb begin
    cmd          = '0;
    op_d         = op_q;
    count_d      = count_q;
    step_d       = step_q;
    len_d        = len_q;
    shown_d      = shown_q;
    val_d        = val_q;
    found_d      = found_q;
    strobe_d     = 1'b0;
    res_d        = res_q;
    case (state_q)
      cdll_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = cdll_pkg::cdll_func_e'(req_i.func);
          val_d   = req_i.value;
          step_d  = '0;
          found_d = 1'b0;
          len_d   = count_q;
          shown_d = (32'(count_q) < ListLimit) ? count_q : CntW'(ListLimit);
          res_d.item_value = '0;
          res_d.last       = 1'b1;
          case (req_i.func)
            cdll_pkg::FUNC_INSERT: begin
              strobe_d = 1'b1;
              if (count_q == CntW'(Capacity)) begin
                res_d.status = cdll_pkg::ST_FULL;
              end else begin
                cmd.wr       = 1'b1;
                count_d      = count_q + 1'b1;
                res_d.status = cdll_pkg::ST_INSERTED;
              end
              res_d.entries = 5'(count_d);
            end
            cdll_pkg::FUNC_DELETE, cdll_pkg::FUNC_LIST: begin
              if (count_q == '0) begin
                strobe_d      = 1'b1;
                res_d.status  = cdll_pkg::ST_NOTFOUND;
                res_d.entries = 5'(count_q);
              end
            end
            default: ;
          endcase
        end
      end
      cdll_pkg::S_WALK: begin
        step_d = step_q + 1'b1;
        if (op_q == cdll_pkg::FUNC_DELETE) begin
          // The first match is dropped; the rest of the ring turns back to order.
          if (match) begin
            cmd.drop = 1'b1;
            count_d  = count_q - 1'b1;
            found_d  = 1'b1;
          end else begin
            cmd.rot = 1'b1;
          end
          if (last_step) begin
            strobe_d         = 1'b1;
            res_d.status     = (found_q || match) ? cdll_pkg::ST_DELETED
                                                  : cdll_pkg::ST_NOTFOUND;
            res_d.item_value = '0;
            res_d.entries    = 5'(count_d);
            res_d.last       = 1'b1;
          end
        end else begin
          // Listing shows the head on each turn until the limit is reached.
          cmd.rot = 1'b1;
          if (step_q < shown_q) begin
            strobe_d         = 1'b1;
            res_d.status     = cdll_pkg::ST_LISTED;
            res_d.item_value = head_value_i;
            res_d.entries    = 5'(count_q);
            res_d.last       = step_q == (shown_q - 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cdll_pkg::S_IDLE;
      op_q     <= cdll_pkg::FUNC_NONE;
      count_q  <= '0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      count_q  <= count_d;
      found_q  <= found_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    len_q   <= len_d;
    shown_q <= shown_d;
    val_q   <= val_d;
    res_q   <= res_d;
  end

  assign busy         = state_q != cdll_pkg::S_IDLE;
  assign cmd_o        = cmd;
  assign count_o      = count_q;
  assign wdata_o      = req_i.value;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/circular_doubly_linked_list_unit.sv @@
// Top level of the circular doubly linked list unit: sequencer and row of cells.
`default_nettype none

// A request (insert, delete first match, or list) is transferred at a rising
// edge where start is high and busy is low. The list is kept in order from the
// head in a row of cells, one value each, which shift towards the head cell.
// Insert writes the cell past the tail unless the list is full; its single
// result appears in the following cycle. Delete and list on n entries turn the
// ring one cell per cycle through all n, with busy high; each result appears
// in the cycle after the step that forms it. Delete gives one result at the
// end of the walk, list gives one result per shown value (up to the listing
// limit), the final one marked by last. Delete or list on an empty list answers
// with a single not-found status and no walk; an unused operation code gives no
// result and starts no walk. Each result is marked by res_strobe_o, high for
// exactly one cycle; the receiver cannot stall, so no result ever waits. Reset
// empties the list at once; no clearing pass is needed.
module circular_doubly_linked_list_unit #(
  parameter int Capacity  = cdll_pkg::Capacity,
  parameter int ListLimit = cdll_pkg::ListLimit
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire cdll_pkg::cdll_req_t req_i,
  output logic                     res_strobe_o,
  output cdll_pkg::cdll_res_t      res_o
);

  localparam int CntW = $clog2(Capacity + 1);

  cdll_pkg::cdll_cmd_t cmd;
  logic [CntW-1:0]     count;
  logic signed [31:0]  wdata;
  logic signed [31:0]  cell_value [Capacity];

  // Sequencer.
  cdll_ctrl #(
    .Capacity  (Capacity),
    .ListLimit (ListLimit)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .head_value_i (cell_value[0]),
    .cmd_o        (cmd),
    .count_o      (count),
    .wdata_o      (wdata),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // Row of cells; each takes the value of the cell above it on a move.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [31:0] nb_value;
    if (i == Capacity - 1) begin : g_end
      assign nb_value = cell_value[i];
    end else begin : g_mid
      assign nb_value = cell_value[i+1];
    end
    cdll_cell #(
      .Capacity (Capacity),
      .Idx      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count),
      .wdata_i      (wdata),
      .nb_value_i   (nb_value),
      .head_value_i (cell_value[0]),
      .value_o      (cell_value[i])
    );
  end

endmodule

`default_nettype wire
